### rtl/tdpt_pkg.sv
// tdpt_pkg: shared types, constants and the microcode table of the
// trial-division prime test. No dependencies.
`default_nettype none

package tdpt_pkg;

	// default operand width
	localparam int VALUE_WIDTH_DEF = 31;

	// first odd trial divisor, its square, and the divisor step
	localparam int FIRST_DIV = 3;
	localparam int FIRST_SQ  = 9;
	localparam int DIV_INC   = 2;
	localparam int SQ_BIAS   = 4;

	// microprogram step addresses
	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_SMALL = 3'd1,
		S_SQ    = 3'd2,
		S_DIV   = 3'd3,
		S_TEST  = 3'd4,
		S_EMIT  = 3'd5
	} step_t;

	// branch conditions
	typedef enum logic [2:0] {
		C_IN_VALID,
		C_TRIVIAL,
		C_SQ_GT,
		C_BIT_LAST,
		C_REM_ZERO,
		C_OUT_FREE
	} cond_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SET_TRIV,
		OP_SET_PRIME,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SET_COMP,
		OP_ADV_D,
		OP_EMIT
	} op_t;

	// one control word: condition, then op and target for each outcome
	typedef struct packed {
		cond_t cond;
		op_t   op_hit;
		step_t tgt_hit;
		op_t   op_miss;
		step_t tgt_miss;
	} uword_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic trivial;
		logic sq_gt;
		logic bit_last;
		logic rem_zero;
		logic out_free;
	} stat_t;

	// microcode read-only table
	function automatic uword_t ucode_rom(input step_t addr);
		uword_t w;
		unique case (addr)
			S_IDLE:  w = '{C_IN_VALID, OP_LOAD,      S_SMALL, OP_NOP,      S_IDLE};
			S_SMALL: w = '{C_TRIVIAL,  OP_SET_TRIV,  S_EMIT,  OP_NOP,      S_SQ};
			S_SQ:    w = '{C_SQ_GT,    OP_SET_PRIME, S_EMIT,  OP_DIV_INIT, S_DIV};
			S_DIV:   w = '{C_BIT_LAST, OP_DIV_STEP,  S_TEST,  OP_DIV_STEP, S_DIV};
			S_TEST:  w = '{C_REM_ZERO, OP_SET_COMP,  S_EMIT,  OP_ADV_D,    S_SQ};
			S_EMIT:  w = '{C_OUT_FREE, OP_EMIT,      S_IDLE,  OP_NOP,      S_EMIT};
			default: w = '{C_OUT_FREE, OP_NOP,       S_IDLE,  OP_NOP,      S_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/tdpt_useq.sv
// tdpt_useq: microcode sequencer with step counter and conditional jumps.
// Depends on tdpt_pkg for the control word table and types.
`default_nettype none

module tdpt_useq import tdpt_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  var stat_t stat,
	output op_t       op,
	output logic      in_ready
);

	step_t  upc_q;
	step_t  upc_nxt;
	uword_t uw;
	logic   hit;

	// fetch control word and evaluate its condition
	always_comb begin
		uw = ucode_rom(upc_q);
		unique case (uw.cond)
			C_IN_VALID: hit = in_valid;
			C_TRIVIAL:  hit = stat.trivial;
			C_SQ_GT:    hit = stat.sq_gt;
			C_BIT_LAST: hit = stat.bit_last;
			C_REM_ZERO: hit = stat.rem_zero;
			C_OUT_FREE: hit = stat.out_free;
			default:    hit = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		upc_nxt = hit ? uw.tgt_hit : uw.tgt_miss;
	end

	// outputs of the current step
	always_comb begin
		op       = hit ? uw.op_hit : uw.op_miss;
		in_ready = (upc_q == S_IDLE);
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/tdpt_datapath.sv
// tdpt_datapath: operand, divisor, running square, bit-serial remainder
// and result register. Depends on tdpt_pkg; driven by tdpt_useq.
`default_nettype none

module tdpt_datapath import tdpt_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  var op_t                op,
	input  wire [VALUE_WIDTH-1:0]  value,
	input  wire                    out_ready,
	output stat_t                  stat,
	output logic                   out_valid,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   is_prime
);

	localparam int DW  = (VALUE_WIDTH + 1) / 2 + 2;
	localparam int SQW = VALUE_WIDTH + 2;
	localparam int CW  = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] v_q;
	logic [DW-1:0]          d_q;
	logic [SQW-1:0]         sq_q;
	logic [DW-1:0]          rem_q;
	logic [CW-1:0]          idx_q;
	logic                   prime_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] tested_value_q;
	logic                   is_prime_q;

	logic [DW:0]  shifted;
	logic [DW:0]  diff;
	logic         ge;
	logic [SQW-1:0] sq_inc;

	// one restoring division step
	always_comb begin
		shifted = {rem_q, v_q[idx_q]};
		diff    = shifted - {1'b0, d_q};
		ge      = (shifted >= {1'b0, d_q});
		sq_inc  = SQW'({d_q, 2'b00}) + SQW'(SQ_BIAS);
	end

	// status back to the sequencer
	always_comb begin
		stat.trivial  = (v_q < VALUE_WIDTH'(3)) || !v_q[0];
		stat.sq_gt    = (sq_q > {2'b00, v_q});
		stat.bit_last = (idx_q == '0);
		stat.rem_zero = (rem_q == '0);
		stat.out_free = !out_valid_q || out_ready;
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				v_q  <= value;
				d_q  <= DW'(FIRST_DIV);
				sq_q <= SQW'(FIRST_SQ);
			end
			OP_SET_TRIV: begin
				prime_q <= (v_q == VALUE_WIDTH'(2));
			end
			OP_SET_PRIME: begin
				prime_q <= 1'b1;
			end
			OP_SET_COMP: begin
				prime_q <= 1'b0;
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				idx_q <= CW'(VALUE_WIDTH - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
				idx_q <= idx_q - CW'(1);
			end
			OP_ADV_D: begin
				d_q  <= d_q + DW'(DIV_INC);
				sq_q <= sq_q + sq_inc;
			end
			OP_EMIT: begin
				tested_value_q <= v_q;
				is_prime_q     <= prime_q;
			end
			default: begin
			end
		endcase
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign tested_value = tested_value_q;
	assign is_prime     = is_prime_q;

endmodule

`default_nettype wire

### rtl/trial_division_prime_test_core.sv
// Trial-division prime test, one odd divisor at a time.
// Request in: value on in_valid/in_ready. Request out: tested_value and
// is_prime on out_valid/out_ready, exactly one per input request.
// Control is a six-step microprogram in tdpt_useq; tdpt_datapath holds the
// operand, the divisor d with its running square, and a bit-serial divider.
// Zero, one, two and even values skip the divisor loop, and odd values below
// nine leave it at the first square check; otherwise each trial divisor
// takes a square check, VALUE_WIDTH remainder bits and a zero test. Worst
// case at 31 bits is roughly 23170 divisors tried.
// One request is worked at a time; in_ready is high only in the idle step.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a stalled receiver blocks only the next emit.
// Reset (asynchronous, active low) returns the sequencer to idle and drops
// out_valid; nothing is kept between requests.
`default_nettype none

module trial_division_prime_test_core import tdpt_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire [VALUE_WIDTH-1:0]  value,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   is_prime
);

	op_t   op;
	stat_t stat;

	// sequencer
	tdpt_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.op       (op),
		.in_ready (in_ready)
	);

	// datapath
	tdpt_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.value        (value),
		.out_ready    (out_ready),
		.stat         (stat),
		.out_valid    (out_valid),
		.tested_value (tested_value),
		.is_prime     (is_prime)
	);

`ifndef ASSERT_OFF
	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in progress");

	// a prime flag is only raised for two or an odd value
	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_prime |-> (tested_value == VALUE_WIDTH'(2)) || tested_value[0])
		else $error("even value other than two flagged prime");

	// zero and one are never prime
	a_small_comp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tested_value < VALUE_WIDTH'(2)) |-> !is_prime)
		else $error("zero or one flagged prime");
`endif

endmodule

`default_nettype wire
